### design/ppmisp_pkg.sv
`default_nettype none

package ppmisp_pkg;

    localparam int DIM_BITS = 16;
    localparam int PIX_BITS = 2 * DIM_BITS;
    localparam int ACC_BITS = 17;

    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
    localparam logic [ACC_BITS-1:0] DIM_MAX = ACC_BITS'((1 << DIM_BITS) - 1);
    localparam logic [ACC_BITS-1:0] SAMPLE_CAP = ACC_BITS'(255);

    localparam logic [7:0] CH_P_UPPER = 8'h50;
    localparam logic [7:0] CH_P_LOWER = 8'h70;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_SIX     = 8'h36;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_MAGIC     = 2'd0,
        ERR_CHAR      = 2'd1,
        ERR_ABOVE_MAX = 2'd2,
        ERR_RANGE     = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_word;

    typedef struct packed {
        t_kind               kind;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [7:0]          max_value;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic                last_pixel;
        t_err                error_code;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Decimal accumulate with saturation: acc * 10 + digit as (acc << 3) + (acc << 1).
    function automatic logic [ACC_BITS-1:0] accumulate(input logic [ACC_BITS-1:0] acc,
                                                       input logic [7:0] b);
        logic [ACC_BITS+3:0] sum;
        logic [7:0]          d;
        d   = b - CH_ZERO;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {(ACC_BITS+0)'(0), d[3:0]};
        if (sum > {4'b0000, ACC_MAX}) begin
            return ACC_MAX;
        end
        return sum[ACC_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### design/ppmisp_in_stage.sv
`default_nettype none

module ppmisp_in_stage
    import ppmisp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_word i_word,
    output logic          o_stall,
    input  wire logic     i_proc_ready,
    output logic          o_word_valid,
    output t_in_word      o_word
);

    logic     r_valid;
    t_in_word r_word;
    logic     load;

    assign load         = !r_valid || i_proc_ready;
    assign o_stall      = !load;
    assign o_word_valid = r_valid;
    assign o_word       = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

### design/ppmisp_parse.sv
`default_nettype none

module ppmisp_parse
    import ppmisp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_word_valid,
    input  wire t_in_word i_word,
    output logic          o_proc_ready,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_result       o_result
);

    typedef enum logic [3:0] {
        PH_MAGIC_LETTER = 4'd0,
        PH_MAGIC_DIGIT  = 4'd1,
        PH_MAGIC_SEP    = 4'd2,
        PH_WIDTH        = 4'd3,
        PH_HEIGHT       = 4'd4,
        PH_MAXVAL       = 4'd5,
        PH_RASTER       = 4'd6,
        PH_DONE         = 4'd7,
        PH_FAILED       = 4'd8
    } t_phase;

    t_phase              r_phase, n_phase, c_phase;
    logic                r_raw, n_raw, c_raw;
    logic                r_cmt, n_cmt, c_cmt;
    logic [ACC_BITS-1:0] r_acc, n_acc, c_acc;
    logic                r_dig, n_dig, c_dig;
    logic [DIM_BITS-1:0] r_w, n_w, c_w;
    logic [DIM_BITS-1:0] r_h, n_h, c_h;
    logic [7:0]          r_lim, n_lim, c_lim;
    logic [1:0]          r_ch, n_ch, c_ch;
    logic [7:0]          r_red, n_red, c_red;
    logic [7:0]          r_grn, n_grn, c_grn;
    logic [PIX_BITS-1:0] r_pix, n_pix, c_pix;

    logic                r_out_valid;
    t_result             r_res;
    logic                res_valid;
    t_result             res;
    logic                take;

    logic [7:0]          b;
    logic                sp;
    logic                dg;
    logic [ACC_BITS-1:0] acc_next;
    logic [PIX_BITS-1:0] area;

    assign o_proc_ready = !r_out_valid || !i_stall;
    assign take         = i_word_valid && o_proc_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_res;

    assign b        = i_word.data_byte;
    assign sp       = is_space(b);
    assign dg       = is_digit(b);
    assign acc_next = accumulate(c_acc, b);
    assign area     = PIX_BITS'(c_w) * PIX_BITS'(c_h);

    // A word marked first sees the reset state before it is parsed.
    always_comb begin
        if (i_word.first) begin
            c_phase = PH_MAGIC_LETTER;
            c_raw   = 1'b0;
            c_cmt   = 1'b0;
            c_acc   = '0;
            c_dig   = 1'b0;
            c_w     = '0;
            c_h     = '0;
            c_lim   = '0;
            c_ch    = '0;
            c_red   = '0;
            c_grn   = '0;
            c_pix   = '0;
        end else begin
            c_phase = r_phase;
            c_raw   = r_raw;
            c_cmt   = r_cmt;
            c_acc   = r_acc;
            c_dig   = r_dig;
            c_w     = r_w;
            c_h     = r_h;
            c_lim   = r_lim;
            c_ch    = r_ch;
            c_red   = r_red;
            c_grn   = r_grn;
            c_pix   = r_pix;
        end
    end

    always_comb begin
        logic [7:0]          smp;
        logic                smp_done;
        logic                fail;
        t_err                code;
        logic                hdr;
        logic [ACC_BITS-1:0] dimv;

        n_phase  = c_phase;
        n_raw    = c_raw;
        n_cmt    = c_cmt;
        n_acc    = c_acc;
        n_dig    = c_dig;
        n_w      = c_w;
        n_h      = c_h;
        n_lim    = c_lim;
        n_ch     = c_ch;
        n_red    = c_red;
        n_grn    = c_grn;
        n_pix    = c_pix;
        smp      = b;
        smp_done = 1'b0;
        fail     = 1'b0;
        code     = ERR_MAGIC;
        hdr      = 1'b0;
        dimv     = (c_acc > DIM_MAX) ? DIM_MAX : c_acc;

        unique case (c_phase)
            PH_MAGIC_LETTER: begin
                if (b == CH_P_UPPER || b == CH_P_LOWER) begin
                    n_phase = PH_MAGIC_DIGIT;
                end else if (!sp) begin
                    fail = 1'b1;
                    code = ERR_MAGIC;
                end
            end
            PH_MAGIC_DIGIT: begin
                if (b == CH_THREE || b == CH_SIX) begin
                    n_raw   = (b == CH_SIX);
                    n_phase = PH_MAGIC_SEP;
                end else begin
                    fail = 1'b1;
                    code = ERR_MAGIC;
                end
            end
            PH_MAGIC_SEP: begin
                if (sp || b == CH_HASH) begin
                    n_cmt   = (b == CH_HASH);
                    n_phase = PH_WIDTH;
                    n_acc   = '0;
                    n_dig   = 1'b0;
                end else begin
                    fail = 1'b1;
                    code = ERR_MAGIC;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                if (c_cmt) begin
                    if (b == CH_LF || b == CH_CR) begin
                        n_cmt = 1'b0;
                    end
                end else if (dg) begin
                    n_acc = acc_next;
                    n_dig = 1'b1;
                end else if (sp || b == CH_HASH) begin
                    if (c_dig) begin
                        n_acc = '0;
                        n_dig = 1'b0;
                        if (c_phase == PH_WIDTH) begin
                            n_w     = dimv[DIM_BITS-1:0];
                            n_phase = PH_HEIGHT;
                            n_cmt   = (b == CH_HASH);
                        end else if (c_phase == PH_HEIGHT) begin
                            n_h     = dimv[DIM_BITS-1:0];
                            n_phase = PH_MAXVAL;
                            n_cmt   = (b == CH_HASH);
                        end else if (b == CH_HASH) begin
                            fail = 1'b1;
                            code = ERR_CHAR;
                        end else if (c_acc == '0 || c_acc > SAMPLE_CAP) begin
                            fail = 1'b1;
                            code = ERR_RANGE;
                        end else begin
                            n_lim   = c_acc[7:0];
                            n_ch    = '0;
                            n_pix   = area;
                            n_phase = (c_w == '0 || c_h == '0) ? PH_DONE : PH_RASTER;
                            hdr     = 1'b1;
                        end
                    end else if (b == CH_HASH) begin
                        n_cmt = 1'b1;
                    end
                end else begin
                    fail = 1'b1;
                    code = ERR_CHAR;
                end
            end
            PH_RASTER: begin
                if (c_raw) begin
                    if (b > c_lim) begin
                        fail = 1'b1;
                        code = ERR_ABOVE_MAX;
                    end else begin
                        smp_done = 1'b1;
                    end
                end else if (dg) begin
                    n_acc = acc_next;
                    n_dig = 1'b1;
                    if (acc_next > {{(ACC_BITS-8){1'b0}}, c_lim}) begin
                        fail = 1'b1;
                        code = ERR_ABOVE_MAX;
                    end
                end else if (sp) begin
                    if (c_dig) begin
                        smp      = c_acc[7:0];
                        n_acc    = '0;
                        n_dig    = 1'b0;
                        smp_done = 1'b1;
                    end
                end else begin
                    fail = 1'b1;
                    code = ERR_CHAR;
                end
            end
            PH_DONE, PH_FAILED: begin
            end
            default: begin
            end
        endcase

        res            = '0;
        res.width      = n_w;
        res.height     = n_h;
        res.max_value  = n_lim;
        res_valid      = 1'b0;

        if (fail) begin
            n_phase        = PH_FAILED;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = code;
        end else if (hdr) begin
            res_valid = 1'b1;
            res.kind  = KIND_HEADER;
        end else if (smp_done) begin
            unique case (c_ch)
                2'd0: begin
                    n_red = smp;
                    n_ch  = 2'd1;
                end
                2'd1: begin
                    n_grn = smp;
                    n_ch  = 2'd2;
                end
                default: begin
                    n_ch           = 2'd0;
                    n_pix          = c_pix - PIX_BITS'(1);
                    res_valid      = 1'b1;
                    res.kind       = KIND_PIXEL;
                    res.red        = c_red;
                    res.green      = c_grn;
                    res.blue       = smp;
                    res.last_pixel = (c_pix == PIX_BITS'(1));
                    if (c_pix == PIX_BITS'(1)) begin
                        n_phase = PH_DONE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC_LETTER;
            r_raw       <= 1'b0;
            r_cmt       <= 1'b0;
            r_acc       <= '0;
            r_dig       <= 1'b0;
            r_w         <= '0;
            r_h         <= '0;
            r_lim       <= '0;
            r_ch        <= '0;
            r_red       <= '0;
            r_grn       <= '0;
            r_pix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_raw   <= n_raw;
                r_cmt   <= n_cmt;
                r_acc   <= n_acc;
                r_dig   <= n_dig;
                r_w     <= n_w;
                r_h     <= n_h;
                r_lim   <= n_lim;
                r_ch    <= n_ch;
                r_red   <= n_red;
                r_grn   <= n_grn;
                r_pix   <= n_pix;
            end
            if (o_proc_ready) begin
                r_out_valid <= take && res_valid;
            end
            if (take && res_valid) begin
                r_res <= res;
            end
        end
    end

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && res_valid && res.kind == KIND_ERROR |=> r_phase == PH_FAILED)
        else $error("error result did not stop the parser");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && res_valid && res.last_pixel |=> r_phase == PH_DONE)
        else $error("last pixel did not finish the image");

    a_raster_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RASTER |-> r_pix != '0)
        else $error("raster phase with no pixels left");

    a_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.kind != KIND_PIXEL |->
            r_res.red == '0 && r_res.green == '0 && r_res.blue == '0 && !r_res.last_pixel)
        else $error("non-pixel result carries pixel data");

endmodule

`default_nettype wire

### design/ppm_image_stream_parser.sv
`default_nettype none

// Streaming parser for P3 and P6 color images that takes one byte word per cycle while the output
// is not stalled and emits a header result, one result per completed pixel, or one error result that
// stops parsing until a word marked first starts the next file; each word passes through an input
// register and then a result register before its result is on the outputs, and one word per cycle
// is sustained while i_stall is low because the decimal accumulate and compare fit in a single pass
// between those registers.

module ppm_image_stream_parser
    import ppmisp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_first,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [1:0]               o_kind,
    output logic [DIM_BITS-1:0]      o_width,
    output logic [DIM_BITS-1:0]      o_height,
    output logic [7:0]               o_max_value,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic                     o_last_pixel,
    output logic [1:0]               o_error_code
);

    t_in_word in_word;
    t_in_word stage_word;
    logic     stage_valid;
    logic     proc_ready;
    t_result  result;

    assign in_word.data_byte = i_data_byte;
    assign in_word.first     = i_first;

    ppmisp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_word       (in_word),
        .o_stall      (o_stall),
        .i_proc_ready (proc_ready),
        .o_word_valid (stage_valid),
        .o_word       (stage_word)
    );

    ppmisp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (stage_valid),
        .i_word       (stage_word),
        .o_proc_ready (proc_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (result)
    );

    assign o_kind       = result.kind;
    assign o_width      = result.width;
    assign o_height     = result.height;
    assign o_max_value  = result.max_value;
    assign o_red        = result.red;
    assign o_green      = result.green;
    assign o_blue       = result.blue;
    assign o_last_pixel = result.last_pixel;
    assign o_error_code = result.error_code;

endmodule

`default_nettype wire
